### rtl/core/pts_pkg.sv
// Package for the priority task scheduler: opcodes, modes, command and status types.
`default_nettype none
package pts_pkg;
    localparam int TASK_SLOTS_DEF = 16;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_TICK  = 3'd1;
    localparam logic [2:0] OP_ITICK = 3'd2;
    localparam logic [2:0] OP_PREEMPT = 3'd3;
    localparam logic [2:0] OP_YIELD = 3'd4;
    localparam logic [2:0] OP_START = 3'd5;
    localparam logic [2:0] OP_CLRPEND = 3'd6;
    localparam logic [2:0] OP_BLOCK = 3'd7;

    localparam logic [1:0] MODE_READY   = 2'd0;
    localparam logic [1:0] MODE_RUNNING = 2'd1;
    localparam logic [1:0] MODE_BLOCKED = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic scan_clr;   // reset scan index and best
        logic scan_step;  // examine one slot
        logic wake;       // scan step also wakes due tasks
        logic skip_cur;   // leave current user task out of the pick
        logic finish;     // apply operation result
        logic out_load;   // load result register
    } pts_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
    } pts_sts_t;
endpackage
`default_nettype wire

### rtl/core/pts_ctrl.sv
// Controller for the priority task scheduler: sequences capture, scan, finish, output.
`default_nettype none
module pts_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire logic [2:0]      operation,
    input  wire pts_pkg::pts_sts_t sts,
    output pts_pkg::pts_cmd_t    cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic [2:0] op_reg;
    logic       needs_scan;

    always_comb
    begin
        case (operation)
            pts_pkg::OP_ADD, pts_pkg::OP_CLRPEND, pts_pkg::OP_BLOCK: needs_scan = 1'b0;
            default: needs_scan = 1'b1;
        endcase
    end

    // a result may sit in the output register while the next beat is worked
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        cmd.wake = (op_reg == pts_pkg::OP_TICK) || (op_reg == pts_pkg::OP_ITICK);
        cmd.skip_cur = (op_reg != pts_pkg::OP_START) && (op_reg != pts_pkg::OP_TICK);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next = needs_scan ? ST_SCAN : ST_FIN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            op_reg <= pts_pkg::OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cmd.load)
                op_reg <= operation;
        end
    end
endmodule
`default_nettype wire

### rtl/core/pts_dp.sv
// Datapath for the priority task scheduler: slot table, scan unit, scheduler state.
`default_nettype none
module pts_dp #(
    parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pts_pkg::pts_cmd_t cmd,
    output pts_pkg::pts_sts_t  sts,
    input  wire logic [2:0]    operation,
    input  wire logic [3:0]    task_slot,
    input  wire logic [7:0]    task_priority,
    input  wire logic [31:0]   wake_time,
    output logic               accepted,
    output logic               switched,
    output logic               current_is_idle,
    output logic [3:0]         current_task,
    output logic               pending_preemption,
    output logic               is_running,
    output logic [31:0]        kernel_time
);
    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);

    logic [TASK_SLOTS-1:0] used_reg;
    logic [1:0]  mode_reg [TASK_SLOTS];
    logic [7:0]  urg_reg  [TASK_SLOTS];
    logic [31:0] wake_reg [TASK_SLOTS];
    logic [31:0] stamp_reg[TASK_SLOTS];

    logic [31:0] stamp_cnt_reg, tick_reg;
    logic [IW-1:0] cur_reg;
    logic        idle_reg, started_reg, pend_reg;
    logic [CW-1:0] used_cnt_reg;

    logic [2:0]  op_reg;
    logic [3:0]  slot_reg;
    logic [7:0]  prio_reg;
    logic [31:0] wk_reg;

    logic [IW-1:0] idx_reg;
    logic        found_reg;
    logic [IW-1:0] best_reg;
    logic [7:0]  best_urg_reg;
    logic [31:0] best_age_reg;

    logic        acc_reg, sw_reg, oidle_reg, opend_reg, orun_reg;
    logic [3:0]  ocur_reg;
    logic [31:0] otime_reg;

    logic        in_range;
    logic [IW-1:0] sidx;
    logic [31:0] now;
    logic [31:0] diff;
    logic        due, blk, wake_it, rdy, cand, better;
    logic [31:0] stamp_eff, age;
    logic [1:0]  mode_eff;

    assign in_range = ({28'd0, slot_reg} < 32'(TASK_SLOTS));
    assign sidx = IW'(slot_reg);
    // scan for the tick ops runs after the tick increments
    assign now = tick_reg;

    assign diff = wake_reg[idx_reg] - now;
    assign blk  = used_reg[idx_reg] && (mode_reg[idx_reg] == pts_pkg::MODE_BLOCKED);
    assign due  = (diff == 32'd0) || diff[31];
    // a plain tick wakes nothing until the scheduler is started
    assign wake_it = cmd.wake && (started_reg || (op_reg == pts_pkg::OP_ITICK)) &&
                     blk && due;
    assign mode_eff = wake_it ? pts_pkg::MODE_READY : mode_reg[idx_reg];
    assign stamp_eff = wake_it ? stamp_cnt_reg : stamp_reg[idx_reg];
    assign rdy  = used_reg[idx_reg] && (mode_eff == pts_pkg::MODE_READY);
    assign cand = rdy && !(cmd.skip_cur && !idle_reg && (idx_reg == cur_reg));
    // ages are taken against the running stamp counter; best age follows each wake
    assign age  = stamp_cnt_reg - stamp_eff;
    assign better = !found_reg || (urg_reg[idx_reg] > best_urg_reg) ||
                    ((urg_reg[idx_reg] == best_urg_reg) && (age > best_age_reg));

    assign sts.scan_last = (32'(idx_reg) == 32'(TASK_SLOTS - 1));

    logic        f_acc, f_idle, f_pend, f_run, f_setcur, f_oldready;
    logic        f_cur_run, f_cur_ok;
    logic [IW-1:0] f_cur;
    logic        higher;

    assign higher = found_reg && (best_urg_reg > urg_reg[cur_reg]);

    always_comb
    begin
        f_acc = 1'b1;
        f_idle = idle_reg;
        f_pend = pend_reg;
        f_run = started_reg;
        f_setcur = 1'b0;
        f_oldready = 1'b0;
        f_cur = cur_reg;
        f_cur_run = 1'b0;
        f_cur_ok = (mode_reg[cur_reg] == pts_pkg::MODE_RUNNING) ||
                   (mode_reg[cur_reg] == pts_pkg::MODE_READY);
        case (op_reg)
            pts_pkg::OP_ADD:
                f_acc = in_range && !used_reg[sidx] && (32'(used_cnt_reg) < 32'(TASK_SLOTS));
            pts_pkg::OP_TICK:
            begin
                if (started_reg)
                begin
                    if (idle_reg)
                    begin
                        if (found_reg)
                        begin
                            f_pend = 1'b0;
                            f_setcur = 1'b1;
                        end
                    end
                    else if (higher)
                    begin
                        f_oldready = 1'b1;
                        f_setcur = 1'b1;
                        f_pend = 1'b0;
                    end
                end
            end
            pts_pkg::OP_ITICK:
            begin
                if (started_reg && !idle_reg && higher)
                    f_pend = 1'b1;
            end
            pts_pkg::OP_PREEMPT:
            begin
                if (started_reg && !idle_reg)
                begin
                    f_pend = 1'b0;
                    if (higher)
                    begin
                        f_oldready = 1'b1;
                        f_setcur = 1'b1;
                    end
                end
                else
                    f_acc = 1'b0;
            end
            pts_pkg::OP_YIELD:
            begin
                if (!found_reg)
                begin
                    if (!idle_reg && f_cur_ok)
                        f_cur_run = 1'b1;
                    else
                        f_idle = 1'b1;
                end
                else
                begin
                    if (!idle_reg && (mode_reg[cur_reg] == pts_pkg::MODE_RUNNING))
                        f_oldready = 1'b1;
                    f_setcur = 1'b1;
                end
            end
            pts_pkg::OP_START:
            begin
                if (!started_reg)
                begin
                    f_run = 1'b1;
                    if (found_reg)
                        f_setcur = 1'b1;
                    else
                        f_idle = 1'b1;
                end
                else
                    f_acc = 1'b0;
            end
            pts_pkg::OP_CLRPEND:
                f_pend = 1'b0;
            pts_pkg::OP_BLOCK:
                f_acc = in_range && used_reg[sidx] &&
                        ((mode_reg[sidx] == pts_pkg::MODE_READY) ||
                         (mode_reg[sidx] == pts_pkg::MODE_RUNNING));
            default: f_acc = 1'b0;
        endcase
        if (f_setcur)
        begin
            f_idle = 1'b0;
            f_cur = best_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            slot_reg <= task_slot;
            prio_reg <= task_priority;
            wk_reg <= wake_time;
        end
        if (cmd.scan_step)
        begin
            if (wake_it)
            begin
                mode_reg[idx_reg] <= pts_pkg::MODE_READY;
                stamp_reg[idx_reg] <= stamp_cnt_reg;
            end
            if (cand && better)
            begin
                best_reg <= idx_reg;
                best_urg_reg <= urg_reg[idx_reg];
                best_age_reg <= age + {31'd0, wake_it};
            end
            else if (wake_it)
                best_age_reg <= best_age_reg + 32'd1;
        end
        if (cmd.finish)
        begin
            if (op_reg == pts_pkg::OP_ADD && f_acc)
            begin
                mode_reg[sidx] <= pts_pkg::MODE_READY;
                urg_reg[sidx] <= prio_reg;
                stamp_reg[sidx] <= stamp_cnt_reg;
            end
            if (op_reg == pts_pkg::OP_BLOCK && f_acc)
            begin
                mode_reg[sidx] <= pts_pkg::MODE_BLOCKED;
                wake_reg[sidx] <= wk_reg;
            end
            if (f_cur_run)
                mode_reg[cur_reg] <= pts_pkg::MODE_RUNNING;
            if (f_oldready)
                mode_reg[cur_reg] <= pts_pkg::MODE_READY;
            if (f_setcur)
                mode_reg[best_reg] <= pts_pkg::MODE_RUNNING;
        end
        if (cmd.out_load)
        begin
            acc_reg <= f_acc;
            sw_reg <= (f_idle != idle_reg) || (!f_idle && (f_cur != cur_reg));
            oidle_reg <= f_idle;
            ocur_reg <= f_idle ? 4'd0 : 4'(f_cur);
            opend_reg <= f_pend;
            orun_reg <= f_run;
            otime_reg <= tick_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            stamp_cnt_reg <= '0;
            tick_reg <= '0;
            cur_reg <= '0;
            idle_reg <= 1'b1;
            started_reg <= 1'b0;
            pend_reg <= 1'b0;
            used_cnt_reg <= '0;
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && ((operation == pts_pkg::OP_TICK) ||
                             (operation == pts_pkg::OP_ITICK)))
                tick_reg <= tick_reg + 32'd1;
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                if (wake_it)
                    stamp_cnt_reg <= stamp_cnt_reg + 32'd1;
                if (cand && better)
                    found_reg <= 1'b1;
                if (!sts.scan_last)
                    idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                if (op_reg == pts_pkg::OP_ADD && f_acc)
                begin
                    used_reg[sidx] <= 1'b1;
                    used_cnt_reg <= used_cnt_reg + 1'b1;
                    stamp_cnt_reg <= stamp_cnt_reg + 32'd1;
                end
                idle_reg <= f_idle;
                cur_reg <= f_cur;
                pend_reg <= f_pend;
                started_reg <= f_run;
            end
        end
    end

    assign accepted = acc_reg;
    assign switched = sw_reg;
    assign current_is_idle = oidle_reg;
    assign current_task = ocur_reg;
    assign pending_preemption = opend_reg;
    assign is_running = orun_reg;
    assign kernel_time = otime_reg;
endmodule
`default_nettype wire

### rtl/core/priority_task_scheduler.sv
// Top level of the priority task scheduler.
// Usage:
//   Input channel: operation, task_slot, task_priority, wake_time with in_valid/in_stall.
//   A beat is taken when in_valid is high and in_stall low.
//   Output channel: one result beat per input beat with out_valid/out_stall.
//   Add, clear pending and block go from capture straight to the finish step.
//   Tick, interrupt tick, preemption, yield and start scan the slot table one
//   slot a cycle between capture and the finish step.
//   One beat is in work at a time; a new beat is taken once the previous
//   result is in the output register, even if the receiver still stalls it.
//   A stalled result holds; the block waits in its finish step until it drains.
//   Reset clears the slot table, counters and flags; idle is current, the
//   scheduler is stopped, and no result is valid.
`default_nettype none
module priority_task_scheduler #(
    parameter int TASK_SLOTS = pts_pkg::TASK_SLOTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  operation,
    input  wire logic [3:0]  task_slot,
    input  wire logic [7:0]  task_priority,
    input  wire logic [31:0] wake_time,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             accepted,
    output logic             switched,
    output logic             current_is_idle,
    output logic [3:0]       current_task,
    output logic             pending_preemption,
    output logic             is_running,
    output logic [31:0]      kernel_time
);
    pts_pkg::pts_cmd_t cmd;
    pts_pkg::pts_sts_t sts;

    pts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .operation(operation),
        .sts(sts), .cmd(cmd)
    );

    pts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .operation(operation), .task_slot(task_slot), .task_priority(task_priority),
        .wake_time(wake_time), .accepted(accepted), .switched(switched),
        .current_is_idle(current_is_idle), .current_task(current_task),
        .pending_preemption(pending_preemption), .is_running(is_running),
        .kernel_time(kernel_time)
    );
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for the priority task scheduler: random op streams, scoreboard.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [7:0]  prio;
        logic [31:0] wake;
    } sched_cmd_t;

    typedef struct packed {
        logic        acc;
        logic        sw;
        logic        idle;
        logic [3:0]  cur;
        logic        pend;
        logic        run;
        logic [31:0] ktime;
    } sched_status_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] operation = '0;
    logic [3:0] task_slot = '0;
    logic [7:0] task_priority = '0;
    logic [31:0] wake_time = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic accepted, switched, current_is_idle, pending_preemption, is_running;
    logic [3:0] current_task;
    logic [31:0] kernel_time;

    always #5 clk = ~clk;

    priority_task_scheduler dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .task_slot(task_slot),
        .task_priority(task_priority), .wake_time(wake_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .accepted(accepted), .switched(switched),
        .current_is_idle(current_is_idle), .current_task(current_task),
        .pending_preemption(pending_preemption), .is_running(is_running),
        .kernel_time(kernel_time)
    );

    // predictor state
    logic        t_used [SLOTS];
    logic [1:0]  t_mode [SLOTS];
    logic [7:0]  t_prio [SLOTS];
    logic [31:0] t_wake [SLOTS];
    logic [31:0] t_stamp [SLOTS];
    logic [31:0] stamp_ctr, tick_ctr;
    logic [3:0]  cur_slot;
    logic        cur_idle, sched_on, pend_flag;
    int          n_used;

    sched_cmd_t    cmd_q[$];
    sched_status_t status_q[$];
    int  errors = 0;
    int  idle_pct = 0;
    int  stall_pct = 0;
    int  quiet_cycles = 0;
    logic [31:0] tick_hint = '0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic int best_ready(input bit skip_cur);
        int best;
        logic [31:0] best_age, age;
        best = -1;
        best_age = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!t_used[i] || t_mode[i] != pts_pkg::MODE_READY) continue;
            if (skip_cur && !cur_idle && i == int'(cur_slot)) continue;
            age = stamp_ctr - t_stamp[i];
            if (best < 0 || t_prio[i] > t_prio[best] ||
                (t_prio[i] == t_prio[best] && age > best_age))
            begin
                best = i;
                best_age = age;
            end
        end
        return best;
    endfunction

    task automatic wake_due_tasks();
        logic [31:0] d;
        for (int i = 0; i < SLOTS; i++)
            if (t_used[i] && t_mode[i] == pts_pkg::MODE_BLOCKED)
            begin
                d = t_wake[i] - tick_ctr;
                if (d == 32'd0 || d[31])
                begin
                    t_mode[i] = pts_pkg::MODE_READY;
                    t_stamp[i] = stamp_ctr;
                    stamp_ctr++;
                end
            end
    endtask

    function automatic void dispatch(input int nxt);
        t_mode[nxt] = pts_pkg::MODE_RUNNING;
        cur_slot = nxt[3:0];
        cur_idle = 1'b0;
    endfunction

    function automatic bit preempt_now();
        int nxt;
        nxt = best_ready(1'b1);
        if (nxt < 0 || t_prio[nxt] <= t_prio[cur_slot]) return 1'b0;
        t_mode[cur_slot] = pts_pkg::MODE_READY;
        dispatch(nxt);
        pend_flag = 1'b0;
        return 1'b1;
    endfunction

    task automatic reset_sched();
        for (int i = 0; i < SLOTS; i++) t_used[i] = 1'b0;
        stamp_ctr = '0;
        tick_ctr = '0;
        cur_slot = '0;
        cur_idle = 1'b1;
        n_used = 0;
        sched_on = 1'b0;
        pend_flag = 1'b0;
    endtask

    task automatic predict_status(input sched_cmd_t c);
        sched_status_t r;
        logic was_idle;
        logic [3:0] was_slot;
        int nxt;
        bit acc;
        was_idle = cur_idle;
        was_slot = cur_slot;
        acc = 1'b0;
        case (c.op)
            pts_pkg::OP_ADD:
                if (!t_used[c.slot] && n_used < SLOTS)
                begin
                    t_used[c.slot] = 1'b1;
                    t_mode[c.slot] = pts_pkg::MODE_READY;
                    t_prio[c.slot] = c.prio;
                    t_stamp[c.slot] = stamp_ctr;
                    stamp_ctr++;
                    n_used++;
                    acc = 1'b1;
                end
            pts_pkg::OP_TICK:
            begin
                acc = 1'b1;
                tick_ctr++;
                if (sched_on)
                begin
                    wake_due_tasks();
                    if (cur_idle)
                    begin
                        nxt = best_ready(1'b0);
                        if (nxt >= 0)
                        begin
                            pend_flag = 1'b0;
                            dispatch(nxt);
                        end
                    end
                    else
                        void'(preempt_now());
                end
            end
            pts_pkg::OP_ITICK:
            begin
                acc = 1'b1;
                tick_ctr++;
                wake_due_tasks();
                if (sched_on && !cur_idle)
                begin
                    nxt = best_ready(1'b1);
                    if (nxt >= 0 && t_prio[nxt] > t_prio[cur_slot]) pend_flag = 1'b1;
                end
            end
            pts_pkg::OP_PREEMPT:
                if (sched_on && !cur_idle)
                begin
                    acc = 1'b1;
                    if (!preempt_now()) pend_flag = 1'b0;
                end
            pts_pkg::OP_YIELD:
            begin
                acc = 1'b1;
                nxt = best_ready(1'b1);
                if (nxt < 0)
                begin
                    if (!cur_idle && (t_mode[cur_slot] == pts_pkg::MODE_RUNNING ||
                                      t_mode[cur_slot] == pts_pkg::MODE_READY))
                        t_mode[cur_slot] = pts_pkg::MODE_RUNNING;
                    else
                        cur_idle = 1'b1;
                end
                else
                begin
                    if (!cur_idle && t_mode[cur_slot] == pts_pkg::MODE_RUNNING)
                        t_mode[cur_slot] = pts_pkg::MODE_READY;
                    dispatch(nxt);
                end
            end
            pts_pkg::OP_START:
                if (!sched_on)
                begin
                    acc = 1'b1;
                    nxt = best_ready(1'b0);
                    if (nxt >= 0) dispatch(nxt);
                    else cur_idle = 1'b1;
                    sched_on = 1'b1;
                end
            pts_pkg::OP_CLRPEND:
            begin
                acc = 1'b1;
                pend_flag = 1'b0;
            end
            default:
                if (t_used[c.slot] && (t_mode[c.slot] == pts_pkg::MODE_READY ||
                                       t_mode[c.slot] == pts_pkg::MODE_RUNNING))
                begin
                    t_mode[c.slot] = pts_pkg::MODE_BLOCKED;
                    t_wake[c.slot] = c.wake;
                    acc = 1'b1;
                end
        endcase
        r.acc = acc;
        r.sw = (was_idle != cur_idle) || (!cur_idle && was_slot != cur_slot);
        r.idle = cur_idle;
        r.cur = cur_idle ? 4'd0 : cur_slot;
        r.pend = pend_flag;
        r.run = sched_on;
        r.ktime = tick_ctr;
        status_q.push_back(r);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_status({operation, task_slot, task_priority, wake_time});
            end
            if (!in_valid || !in_stall)
            begin
                if (cmd_q.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    sched_cmd_t c;
                    c = cmd_q.pop_front();
                    in_valid <= 1'b1;
                    operation <= c.op;
                    task_slot <= c.slot;
                    task_priority <= c.prio;
                    wake_time <= c.wake;
                end
                else
                    in_valid <= 1'b0;
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (status_q.size() == 0)
                begin
                    $display("unexpected result beat");
                    errors++;
                end
                else
                begin
                    sched_status_t e;
                    e = status_q.pop_front();
                    if (accepted !== e.acc)
                        report_mismatch("accepted", 32'(accepted), 32'(e.acc));
                    if (switched !== e.sw)
                        report_mismatch("switched", 32'(switched), 32'(e.sw));
                    if (current_is_idle !== e.idle)
                        report_mismatch("current_is_idle", 32'(current_is_idle),
                                        32'(e.idle));
                    if (current_task !== e.cur)
                        report_mismatch("current_task", 32'(current_task), 32'(e.cur));
                    if (pending_preemption !== e.pend)
                        report_mismatch("pending_preemption", 32'(pending_preemption),
                                        32'(e.pend));
                    if (is_running !== e.run)
                        report_mismatch("is_running", 32'(is_running), 32'(e.run));
                    if (kernel_time !== e.ktime)
                        report_mismatch("kernel_time", kernel_time, e.ktime);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic sched_cmd_t mk(input logic [2:0] op, input logic [3:0] slot,
                                      input logic [7:0] prio, input logic [31:0] wake);
        sched_cmd_t c;
        c.op = op;
        c.slot = slot;
        c.prio = prio;
        c.wake = wake;
        return c;
    endfunction

    function automatic logic [31:0] rand_wake();
        case ($urandom_range(3))
            0: return tick_hint + $urandom_range(8);
            1: return tick_hint - $urandom_range(8);
            2: return tick_hint + 32'h8000_0000 - $urandom_range(2);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random(input int n);
        logic [2:0] op;
        logic [7:0] pr;
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 3) op = pts_pkg::OP_TICK;
            else op = 3'($urandom_range(7));
            if (op == pts_pkg::OP_TICK || op == pts_pkg::OP_ITICK) tick_hint++;
            if ($urandom_range(3) == 0) pr = 8'($urandom);
            else pr = 8'($urandom_range(3));
            cmd_q.push_back(mk(op, 4'($urandom_range(15)), pr, rand_wake()));
        end
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || in_valid || status_q.size() > 0) @(posedge clk);
    endtask

    initial
    begin
        reset_sched();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        // directed: empty start checks, adds with extremes, ties, blocks, wraps
        cmd_q.push_back(mk(pts_pkg::OP_YIELD, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_PREEMPT, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_BLOCK, 4'd3, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_ITICK, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_ADD, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_ADD, 4'd15, 8'd255, 32'hFFFF_FFFF));
        cmd_q.push_back(mk(pts_pkg::OP_ADD, 4'd15, 8'd1, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_ADD, 4'd5, 8'd255, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_START, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_START, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_BLOCK, 4'd15, 8'd0, 32'd3));
        cmd_q.push_back(mk(pts_pkg::OP_BLOCK, 4'd15, 8'd0, 32'd3));
        cmd_q.push_back(mk(pts_pkg::OP_YIELD, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_BLOCK, 4'd5, 8'd0, 32'h8000_0002));
        cmd_q.push_back(mk(pts_pkg::OP_ITICK, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_ITICK, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_PREEMPT, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_TICK, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_CLRPEND, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_YIELD, 4'd0, 8'd0, 32'd0));
        cmd_q.push_back(mk(pts_pkg::OP_TICK, 4'd0, 8'd0, 32'd0));
        tick_hint = 32'd4;
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 71) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 71) : 0;
            queue_random(200);
            // fill table so capacity limits are hit
            for (int s = 0; s < SLOTS; s++)
                cmd_q.push_back(mk(pts_pkg::OP_ADD, s[3:0], 8'($urandom), 32'd0));
            queue_random(170);
            drain();
        end
        idle_pct = 0;
        stall_pct = 0;
        repeat (40) @(posedge clk);
        if (errors == 0 && status_q.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire
